@@ hw/rtl/lrbs_pkg.sv @@
`default_nettype none

package lrbs_pkg;

    // Field widths
    localparam int DELAY_W = 24;
    localparam int COUNT_W = 8;
    localparam int CAUSE_W = 8;
    localparam int OP_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Event opcodes
    localparam logic [OP_W-1:0] OP_DRIVER_START = 3'd0;
    localparam logic [OP_W-1:0] OP_CONNECT_BEGIN = 3'd1;
    localparam logic [OP_W-1:0] OP_DISCONNECTED = 3'd2;
    localparam logic [OP_W-1:0] OP_GOT_ADDRESS = 3'd3;
    localparam logic [OP_W-1:0] OP_MS_TICK = 3'd4;
    localparam logic [OP_W-1:0] OP_START_FAILED = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REBOOT_AFTER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LIMIT = 3'd4;

    // Configuration reset values
    localparam logic [DELAY_W-1:0] RST_RETRY_BASE    = 24'd1000;
    localparam logic [DELAY_W-1:0] RST_RETRY_MAX     = 24'd60000;
    localparam logic [COUNT_W-1:0] RST_MAX_ATTEMPTS  = 8'd0;
    localparam logic [DELAY_W-1:0] RST_REBOOT_AFTER  = 24'd0;
    localparam logic [COUNT_W-1:0] RST_INITIAL_LIMIT = 8'd5;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_CONNECT   = 3'd1,
        ACT_FAILED    = 3'd2,
        ACT_CONNECTED = 3'd3,
        ACT_REBOOT    = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        LINK_IDLE         = 2'd0,
        LINK_CONNECTING   = 2'd1,
        LINK_RECONNECTING = 2'd2,
        LINK_CONNECTED    = 2'd3
    } t_conn_status;

    // Classified event kind, produced by the front end
    typedef enum logic [2:0] {
        CMD_START,
        CMD_BEGIN,
        CMD_DISC,
        CMD_ADDR,
        CMD_TICK,
        CMD_STFAIL,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [CAUSE_W-1:0] reason;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [CAUSE_W-1:0] reason;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         action;
        logic [1:0]         conn_status;
        logic [COUNT_W-1:0] runtime_attempts;
        logic [COUNT_W-1:0] first_connect_retries;
        logic [DELAY_W-1:0] current_delay_ms;
        logic [DELAY_W-1:0] outage_length_ms;
        logic [CAUSE_W-1:0] disconnect_cause;
    } t_out_item;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

`default_nettype wire

@@ hw/rtl/lrbs_front.sv @@
`default_nettype none

module lrbs_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire lrbs_pkg::t_in_item i_item,
    output logic                   o_cmd_valid,
    output lrbs_pkg::t_cmd         o_cmd,
    input  wire logic              i_cmd_take
);
    import lrbs_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_cmd       cls;
    logic       wr_en;

    // Classify the incoming event
    always_comb begin
        cls.reason = i_item.reason;
        case (i_item.opcode)
            OP_DRIVER_START:  cls.kind = CMD_START;
            OP_CONNECT_BEGIN: cls.kind = CMD_BEGIN;
            OP_DISCONNECTED:  cls.kind = CMD_DISC;
            OP_GOT_ADDRESS:   cls.kind = CMD_ADDR;
            OP_MS_TICK:       cls.kind = CMD_TICK;
            OP_START_FAILED:  cls.kind = CMD_STFAIL;
            default:          cls.kind = CMD_NOP;
        endcase
    end

    assign full        = (r_count == 2'd2);
    assign wr_en       = push && !full;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_mem[r_rd_ptr];

    // Store classified commands
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= cls;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({wr_en, i_cmd_take})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lrbs_engine.sv @@
`default_nettype none

module lrbs_engine #(
    parameter int TIME_BITS = 24
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lrbs_pkg::t_cfg_wr   i_cfg,
    input  wire logic                i_cmd_valid,
    input  wire lrbs_pkg::t_cmd      i_cmd,
    output logic                     o_cmd_take,
    input  wire logic                i_res_full,
    output logic                     o_res_push,
    output lrbs_pkg::t_out_item      o_res
);
    import lrbs_pkg::*;

    localparam int CW = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Configuration registers
    logic [DELAY_W-1:0] r_base;
    logic [DELAY_W-1:0] r_max;
    logic [COUNT_W-1:0] r_max_att;
    logic [DELAY_W-1:0] r_reboot;
    logic [COUNT_W-1:0] r_init_lim;

    // Supervisor state
    logic                 r_driver_up, n_driver_up;
    logic                 r_link_up, n_link_up;
    logic                 r_first_busy, n_first_busy;
    logic                 r_ever_addr, n_ever_addr;
    logic                 r_recovery, n_recovery;
    logic                 r_pending, n_pending;
    logic                 r_halted, n_halted;
    logic [COUNT_W-1:0]   r_retries, n_retries;
    logic [COUNT_W-1:0]   r_attempts, n_attempts;
    logic [DELAY_W-1:0]   r_last_delay, n_last_delay;
    logic [TIME_BITS-1:0] r_outage, n_outage;
    logic [TIME_BITS-1:0] r_countdown, n_countdown;
    logic [CAUSE_W-1:0]   r_last_cause, n_last_cause;

    // Scheduling datapath
    logic                 link_eff;
    logic                 s_guard;
    logic [COUNT_W-1:0]   a_eff;
    logic [TIME_BITS-1:0] o_eff;
    logic [COUNT_W:0]     next_att;
    logic                 s_budget;
    logic [DELAY_W-1:0]   d0;
    logic [2*DELAY_W-1:0] shifted;
    logic [DELAY_W-1:0]   s_delay;
    logic [DELAY_W-1:0]   c_min;
    logic [CW-1:0]        c_ext;
    logic [CW-1:0]        c_sat;
    logic [TIME_BITS-1:0] s_count;

    // Tick datapath
    logic [TIME_BITS-1:0] out_inc;
    logic                 t_budget;

    t_action      act;
    t_conn_status ls;
    logic [CW-1:0] outage_ext;

    assign o_cmd_take = i_cmd_valid && !i_res_full;
    assign o_res_push = o_cmd_take;

    // Work out the next attempt: budget, backoff delay and countdown
    always_comb begin
        link_eff = (i_cmd.kind == CMD_DISC) ? 1'b0 : r_link_up;
        s_guard  = r_driver_up && !r_first_busy && !link_eff && r_ever_addr;
        a_eff    = r_recovery ? r_attempts : '0;
        o_eff    = r_recovery ? r_outage : '0;
        next_att = {1'b0, a_eff} + {{COUNT_W{1'b0}}, 1'b1};
        s_budget = ((r_max_att != '0) && (next_att > {1'b0, r_max_att}))
                || ((r_reboot != '0) && (CW'(o_eff) >= CW'(r_reboot)));
        // Delay of attempt n is min(base, max) doubled n-1 times, capped at max
        d0      = (r_base > r_max) ? r_max : r_base;
        shifted = {{DELAY_W{1'b0}}, d0} << a_eff[4:0];
        if (d0 == '0) begin
            s_delay = '0;
        end else if ((a_eff >= COUNT_W'(DELAY_W)) ||
                     (shifted > {{DELAY_W{1'b0}}, r_max})) begin
            s_delay = r_max;
        end else begin
            s_delay = shifted[DELAY_W-1:0];
        end
        c_min   = (s_delay == '0) ? {{(DELAY_W-1){1'b0}}, 1'b1} : s_delay;
        c_ext   = CW'(c_min);
        c_sat   = (c_ext > CW'(TIME_MAX)) ? CW'(TIME_MAX) : c_ext;
        s_count = c_sat[TIME_BITS-1:0];
    end

    // Outage count on a tick and the budget check at expiry
    always_comb begin
        out_inc  = (r_recovery && (r_outage != TIME_MAX)) ? r_outage + 1'b1 : r_outage;
        t_budget = ((r_max_att != '0) && (r_attempts > r_max_att))
                || ((r_reboot != '0) && (CW'(out_inc) >= CW'(r_reboot)));
    end

    // Apply one event
    always_comb begin
        n_driver_up  = r_driver_up;
        n_link_up    = r_link_up;
        n_first_busy = r_first_busy;
        n_ever_addr  = r_ever_addr;
        n_recovery   = r_recovery;
        n_pending    = r_pending;
        n_halted     = r_halted;
        n_retries    = r_retries;
        n_attempts   = r_attempts;
        n_last_delay = r_last_delay;
        n_outage     = r_outage;
        n_countdown  = r_countdown;
        n_last_cause = r_last_cause;
        act          = ACT_NONE;

        if (!r_halted) begin
            case (i_cmd.kind)
                CMD_START: begin
                    n_driver_up = 1'b1;
                end
                CMD_BEGIN: begin
                    n_driver_up  = 1'b1;
                    n_link_up    = 1'b0;
                    n_first_busy = 1'b1;
                    n_ever_addr  = 1'b0;
                    n_retries    = '0;
                    n_last_cause = '0;
                    n_recovery   = 1'b0;
                    n_pending    = 1'b0;
                    n_attempts   = '0;
                    n_last_delay = '0;
                    n_outage     = '0;
                    n_countdown  = '0;
                    act          = ACT_CONNECT;
                end
                CMD_ADDR: begin
                    n_link_up    = 1'b1;
                    n_first_busy = 1'b0;
                    n_retries    = '0;
                    n_ever_addr  = 1'b1;
                    n_recovery   = 1'b0;
                    n_pending    = 1'b0;
                    n_attempts   = '0;
                    n_last_delay = '0;
                    n_outage     = '0;
                    n_countdown  = '0;
                    act          = ACT_CONNECTED;
                end
                CMD_TICK: begin
                    n_outage = out_inc;
                    if (r_pending) begin
                        if (r_countdown > {{(TIME_BITS-1){1'b0}}, 1'b1}) begin
                            n_countdown = r_countdown - 1'b1;
                        end else begin
                            n_countdown = '0;
                            n_pending   = 1'b0;
                            if (r_recovery && !r_link_up && !r_first_busy) begin
                                if (t_budget) begin
                                    n_halted = 1'b1;
                                    act      = ACT_REBOOT;
                                end else begin
                                    act = ACT_CONNECT;
                                end
                            end
                        end
                    end
                end
                CMD_DISC, CMD_STFAIL: begin
                    if (i_cmd.kind == CMD_DISC) begin
                        n_link_up    = 1'b0;
                        n_last_cause = i_cmd.reason;
                    end
                    if ((i_cmd.kind == CMD_DISC) && r_first_busy &&
                        (r_retries < r_init_lim)) begin
                        n_retries = r_retries + 1'b1;
                        act       = ACT_CONNECT;
                    end else if ((i_cmd.kind == CMD_DISC) && r_first_busy) begin
                        n_first_busy = 1'b0;
                        act          = ACT_FAILED;
                    end else if (s_guard) begin
                        // Open a new outage on the first loss
                        if (!r_recovery) begin
                            n_recovery   = 1'b1;
                            n_outage     = '0;
                            n_attempts   = '0;
                            n_last_delay = '0;
                        end
                        if (!r_pending) begin
                            if (s_budget) begin
                                n_halted = 1'b1;
                                act      = ACT_REBOOT;
                            end else begin
                                n_attempts   = next_att[COUNT_W] ? {COUNT_W{1'b1}}
                                                                 : next_att[COUNT_W-1:0];
                                n_last_delay = s_delay;
                                n_countdown  = s_count;
                                n_pending    = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    act = ACT_NONE;
                end
            endcase
        end
    end

    // Build the result from the updated state
    always_comb begin
        if (n_link_up) begin
            ls = LINK_CONNECTED;
        end else if (n_first_busy) begin
            ls = LINK_CONNECTING;
        end else if (n_recovery) begin
            ls = LINK_RECONNECTING;
        end else begin
            ls = LINK_IDLE;
        end
        outage_ext                  = CW'(n_outage);
        o_res.action                = act;
        o_res.conn_status           = ls;
        o_res.runtime_attempts      = n_attempts;
        o_res.first_connect_retries = n_retries;
        o_res.current_delay_ms      = n_last_delay;
        o_res.outage_length_ms      = outage_ext[DELAY_W-1:0];
        o_res.disconnect_cause      = n_last_cause;
    end

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= RST_RETRY_BASE;
            r_max      <= RST_RETRY_MAX;
            r_max_att  <= RST_MAX_ATTEMPTS;
            r_reboot   <= RST_REBOOT_AFTER;
            r_init_lim <= RST_INITIAL_LIMIT;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_RETRY_BASE:    r_base     <= i_cfg.data;
                CFG_RETRY_MAX:     r_max      <= i_cfg.data;
                CFG_MAX_ATTEMPTS:  r_max_att  <= i_cfg.data[COUNT_W-1:0];
                CFG_REBOOT_AFTER:  r_reboot   <= i_cfg.data;
                CFG_INITIAL_LIMIT: r_init_lim <= i_cfg.data[COUNT_W-1:0];
                default:           r_base     <= r_base;
            endcase
        end
    end

    // Advance supervisor state on each transaction taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_driver_up  <= 1'b0;
            r_link_up    <= 1'b0;
            r_first_busy <= 1'b0;
            r_ever_addr  <= 1'b0;
            r_recovery   <= 1'b0;
            r_pending    <= 1'b0;
            r_halted     <= 1'b0;
            r_retries    <= '0;
            r_attempts   <= '0;
            r_last_delay <= '0;
            r_outage     <= '0;
            r_countdown  <= '0;
            r_last_cause <= '0;
        end else if (o_cmd_take) begin
            r_driver_up  <= n_driver_up;
            r_link_up    <= n_link_up;
            r_first_busy <= n_first_busy;
            r_ever_addr  <= n_ever_addr;
            r_recovery   <= n_recovery;
            r_pending    <= n_pending;
            r_halted     <= n_halted;
            r_retries    <= n_retries;
            r_attempts   <= n_attempts;
            r_last_delay <= n_last_delay;
            r_outage     <= n_outage;
            r_countdown  <= n_countdown;
            r_last_cause <= n_last_cause;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lrbs_outq.sv @@
`default_nettype none

module lrbs_outq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire lrbs_pkg::t_out_item i_res,
    output logic                     o_full,
    output logic                     empty,
    input  wire logic                pop,
    output lrbs_pkg::t_out_item      o_result
);
    import lrbs_pkg::*;

    t_out_item  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       rd_en;

    assign o_full   = (r_count == 2'd2);
    assign empty    = (r_count == 2'd0);
    assign rd_en    = pop && !empty;
    assign o_result = r_mem[r_rd_ptr];

    // Store finished results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/link_reconnect_backoff_supervisor.sv @@
// Link reconnect supervisor with exponential backoff and a retry budget. Events
// (driver started, connect begin, disconnect with reason, address obtained,
// 1 ms tick, connect-start failure) are pushed in as transactions; each one
// yields exactly one result with the action to take and a snapshot of the link
// state, in order. One transaction is accepted per clock cycle while results are
// popped as they come; an accepted transaction waits in the two-entry command
// queue behind the classifier, then the state update writes its result straight
// into the two-entry result queue. Configuration writes take effect at the
// next edge and should be made while no transaction is in flight. After a
// reboot request every further event is answered with action none until reset.
`default_nettype none

module link_reconnect_backoff_supervisor #(
    parameter int TIME_BITS = 24
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      push,
    output logic                                           full,
    input  wire lrbs_pkg::t_in_item                        i_item,
    output logic                                           empty,
    input  wire logic                                      pop,
    output lrbs_pkg::t_out_item                            o_result,
    input  wire logic                                      i_cfg_we,
    input  wire logic [lrbs_pkg::CFG_IDX_W-1:0]            i_cfg_idx,
    input  wire logic [lrbs_pkg::CFG_DATA_W-1:0]           i_cfg_data
);
    import lrbs_pkg::*;

    logic      cmd_valid;
    t_cmd      cmd;
    logic      cmd_take;
    logic      res_full;
    logic      res_push;
    t_out_item res;
    t_cfg_wr   cfg;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // Accept and classify events
    lrbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // Carry out events against supervisor state
    lrbs_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // Hold results until popped
    lrbs_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_push),
        .i_res    (res),
        .o_full   (res_full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
